// ===== sv/bdpc_pkg.sv =====
package bdpc_pkg;

    localparam int COORD_BITS_DEF    = 12;
    localparam int SUBPIXEL_BITS_DEF = 4;

    localparam int RAD_W     = 13;          // dab radius
    localparam int RAD2_W    = 2 * RAD_W;   // squared radius
    localparam int FRAC_W    = 16;          // Q0.16 fractions
    localparam int ONE_W     = FRAC_W + 1;  // Q0.16 values that may reach 1.0
    localparam int PCT_W     = 7;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int TNUM_W    = 23;          // 100*d - 65536*H
    localparam int DIV100_W  = 47;          // 23-bit value times reciprocal
    localparam int DIV100_SH = 30;

    localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;
    localparam logic [ONE_W-1:0]  Q16_ONE  = 17'h10000;
    localparam logic [23:0]       DIV100_M = 24'd10737419;   // ceil(2^30 / 100)
    localparam logic [17:0]       SMOOTH_K = 18'd196608;     // 3.0 in Q2.16
    localparam logic [49:0]       ROUND32  = 50'h0_0000_8000_0000;
    localparam logic [24:0]       ROUND16  = 25'h8000;
    localparam logic [ONE_W-1:0]  CA_TINY  = 17'd6;          // ca*10000 <= 65536

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HARDNESS = 2'd0,
        CFG_OPACITY  = 2'd1,
        CFG_FLOW     = 2'd2,
        CFG_COLOR    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MIX_FULL,
        MIX_ZERO,
        MIX_DIV
    } t_mix_mode;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic [ONE_W-1:0] ca;
        logic             in_dab;
    } t_pix;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic             wr;
        t_mix_mode        mode;
        logic [ONE_W-1:0] ta;
    } t_blend;

    function automatic logic [CH_W-1:0] blend8(input logic [CH_W-1:0] dst,
                                               input logic [CH_W-1:0] brush,
                                               input logic [ONE_W-1:0] mix);
        logic [24:0] sum;
        sum = 25'(dst) * 25'(Q16_ONE - mix) + 25'(brush) * 25'(mix) + ROUND16;
        return sum[23:16];
    endfunction

endpackage

// ===== sv/bdpc_udiv.sv =====
// Restoring divider, one quotient bit per stage, sideband travels alongside.
module bdpc_udiv #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 7,
    parameter int QUO_W = 16,
    parameter int SB_W  = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [SB_W-1:0]  i_sb,
    output logic             o_valid,
    output logic [QUO_W-1:0] o_quo,
    output logic [SB_W-1:0]  o_sb
);

    localparam int CMP_W = NUM_W + DEN_W;

    logic [QUO_W:1]   r_vld;
    logic [NUM_W-1:0] r_rem [1:QUO_W];
    logic [DEN_W-1:0] r_den [1:QUO_W];
    logic [QUO_W-1:0] r_quo [1:QUO_W];
    logic [SB_W-1:0]  r_sb  [1:QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic             vld_in;
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [SB_W-1:0]  sb_in;
        logic [CMP_W-1:0] trial;
        logic             take;
        logic [QUO_W-1:0] n_quo;

        if (g == 0) begin : g_first
            assign vld_in = i_valid;
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign vld_in = r_vld[g];
            assign rem_in = r_rem[g];
            assign den_in = r_den[g];
            assign quo_in = r_quo[g];
            assign sb_in  = r_sb[g];
        end

        assign trial = CMP_W'(den_in) << (QUO_W - 1 - g);
        assign take  = CMP_W'(rem_in) >= trial;

        always_comb begin
            n_quo = quo_in;
            n_quo[QUO_W-1-g] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= take ? NUM_W'(CMP_W'(rem_in) - trial) : rem_in;
                r_den[g+1] <= den_in;
                r_quo[g+1] <= n_quo;
                r_sb[g+1]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_sb    = r_sb[QUO_W];

endmodule

// ===== sv/bdpc_rootdiv.sv =====
// q = floor(2^QUO_W * sqrt(d2 / r2)), one bit a stage.
// Keeps rem = d2*2^(2*QUO_W) - q^2*r2 and p = q*r2, so no multiplier is needed.
module bdpc_rootdiv #(
    parameter int RAD_W = 13,
    parameter int QUO_W = 16,
    parameter int SB_W  = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [2*RAD_W-1:0] i_d2,
    input  logic [2*RAD_W-1:0] i_r2,
    input  logic [SB_W-1:0]    i_sb,
    output logic               o_valid,
    output logic [QUO_W-1:0]   o_quo,
    output logic [SB_W-1:0]    o_sb
);

    localparam int R2_W  = 2 * RAD_W;
    localparam int X_W   = R2_W + 2 * QUO_W;
    localparam int P_W   = R2_W + QUO_W;
    localparam int CMP_W = X_W + 2;

    logic [QUO_W:1]   r_vld;
    logic [X_W-1:0]   r_rem [1:QUO_W];
    logic [P_W-1:0]   r_p   [1:QUO_W];
    logic [R2_W-1:0]  r_r2  [1:QUO_W];
    logic [QUO_W-1:0] r_quo [1:QUO_W];
    logic [SB_W-1:0]  r_sb  [1:QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int K = QUO_W - 1 - g;
        logic             vld_in;
        logic [X_W-1:0]   rem_in;
        logic [P_W-1:0]   p_in;
        logic [R2_W-1:0]  r2_in;
        logic [QUO_W-1:0] quo_in;
        logic [SB_W-1:0]  sb_in;
        logic [CMP_W-1:0] trial;
        logic             take;
        logic [QUO_W-1:0] n_quo;

        if (g == 0) begin : g_first
            assign vld_in = i_valid;
            assign rem_in = {i_d2, {(2*QUO_W){1'b0}}};
            assign p_in   = '0;
            assign r2_in  = i_r2;
            assign quo_in = '0;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign vld_in = r_vld[g];
            assign rem_in = r_rem[g];
            assign p_in   = r_p[g];
            assign r2_in  = r_r2[g];
            assign quo_in = r_quo[g];
            assign sb_in  = r_sb[g];
        end

        // (m + 2^K r)^2 - m^2 with m = q*r
        assign trial = (CMP_W'(p_in) << (K + 1)) + (CMP_W'(r2_in) << (2 * K));
        assign take  = CMP_W'(rem_in) >= trial;

        always_comb begin
            n_quo = quo_in;
            n_quo[K] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= take ? X_W'(CMP_W'(rem_in) - trial) : rem_in;
                r_p[g+1]   <= take ? p_in + (P_W'(r2_in) << K) : p_in;
                r_r2[g+1]  <= r2_in;
                r_quo[g+1] <= n_quo;
                r_sb[g+1]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_sb    = r_sb[QUO_W];

endmodule

// ===== sv/brush_dab_pixel_composite.sv =====
// Channel   Direction  Handshake                  Payload
// cfg       in         i_cfg_we                   i_cfg_idx, i_cfg_data
// pixel     in         i_in_valid / o_in_stall    pixel, centre, radius, dest RGBA
// result    out        o_out_valid / i_out_stall  out RGBA, o_write_enable
//
// One pixel request per cycle while the output is not held; the pipeline holds the three 16-stage
// bit-per-stage units (distance root-divide, falloff divide, colour mix divide).
// Synchronous active-low reset clears the valid bits and loads register defaults.
// A held output stalls the whole pipeline in place; bubbles travel with it.
module brush_dab_pixel_composite #(
    parameter int COORD_BITS    = bdpc_pkg::COORD_BITS_DEF,
    parameter int SUBPIXEL_BITS = bdpc_pkg::SUBPIXEL_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bdpc_pkg::COLOR_W-1:0]          i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [COORD_BITS-1:0]                 i_pixel_x,
    input  logic [COORD_BITS-1:0]                 i_pixel_y,
    input  logic [COORD_BITS+SUBPIXEL_BITS-1:0]   i_center_x,
    input  logic [COORD_BITS+SUBPIXEL_BITS-1:0]   i_center_y,
    input  logic [bdpc_pkg::RAD_W-1:0]            i_dab_radius,
    input  logic [bdpc_pkg::CH_W-1:0]             i_dest_red,
    input  logic [bdpc_pkg::CH_W-1:0]             i_dest_green,
    input  logic [bdpc_pkg::CH_W-1:0]             i_dest_blue,
    input  logic [bdpc_pkg::CH_W-1:0]             i_dest_alpha,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [bdpc_pkg::CH_W-1:0]             o_out_red,
    output logic [bdpc_pkg::CH_W-1:0]             o_out_green,
    output logic [bdpc_pkg::CH_W-1:0]             o_out_blue,
    output logic [bdpc_pkg::CH_W-1:0]             o_out_alpha,
    output logic                                  o_write_enable
);

    localparam int CEN_W  = COORD_BITS + SUBPIXEL_BITS;
    localparam int SQ_W   = 2 * CEN_W;
    localparam int D2_W   = SQ_W + 1;
    localparam int R2W    = bdpc_pkg::RAD2_W;
    localparam int CMPD_W = (D2_W > R2W) ? D2_W : R2W;
    localparam int ONE_W  = bdpc_pkg::ONE_W;
    localparam int FRAC_W = bdpc_pkg::FRAC_W;
    localparam int PCT_W  = bdpc_pkg::PCT_W;
    localparam int TNUM_W = bdpc_pkg::TNUM_W;
    localparam int DV_W   = bdpc_pkg::DIV100_W;
    localparam int DV_SH  = bdpc_pkg::DIV100_SH;
    localparam int PIX_W  = $bits(bdpc_pkg::t_pix);
    localparam int BLD_W  = $bits(bdpc_pkg::t_blend);
    localparam int MNUM_W = ONE_W + FRAC_W;

    // ---------------- configuration ----------------
    logic [PCT_W-1:0]             r_hard;
    logic [PCT_W-1:0]             r_opac;
    logic [PCT_W-1:0]             r_flow;
    logic [bdpc_pkg::COLOR_W-1:0] r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hard  <= 7'd50;
            r_opac  <= bdpc_pkg::PCT_MAX;
            r_flow  <= bdpc_pkg::PCT_MAX;
            r_color <= '0;
        end else if (i_cfg_we) begin
            case (bdpc_pkg::t_cfg_idx'(i_cfg_idx))
                bdpc_pkg::CFG_HARDNESS: r_hard  <= i_cfg_data[PCT_W-1:0];
                bdpc_pkg::CFG_OPACITY:  r_opac  <= i_cfg_data[PCT_W-1:0];
                bdpc_pkg::CFG_FLOW:     r_flow  <= i_cfg_data[PCT_W-1:0];
                bdpc_pkg::CFG_COLOR:    r_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [PCT_W-1:0] hard_sat;
    logic [PCT_W-1:0] opac_sat;
    logic [PCT_W-1:0] flow_sat;

    assign hard_sat = (r_hard > bdpc_pkg::PCT_MAX) ? bdpc_pkg::PCT_MAX : r_hard;
    assign opac_sat = (r_opac > bdpc_pkg::PCT_MAX) ? bdpc_pkg::PCT_MAX : r_opac;
    assign flow_sat = (r_flow > bdpc_pkg::PCT_MAX) ? bdpc_pkg::PCT_MAX : r_flow;

    // opacity ceiling, follows the register through r_op_prod and then r_op
    logic [DV_W-1:0]  r_op_prod;
    logic [ONE_W-1:0] r_op;

    always_ff @(posedge i_clk) begin
        r_op_prod <= DV_W'({opac_sat, {FRAC_W{1'b0}}} + TNUM_W'(50)) * DV_W'(bdpc_pkg::DIV100_M);
        r_op      <= r_op_prod[DV_SH+ONE_W-1:DV_SH];
    end

    // ---------------- flow control ----------------
    logic r_out_valid;
    logic en;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ---------------- S1: offsets ----------------
    logic [CEN_W-1:0] ux, uy;
    logic [CEN_W-1:0] n_adx, n_ady;
    logic [ONE_W-1:0] n_ca;

    assign ux    = {i_pixel_x, 1'b1, {(SUBPIXEL_BITS-1){1'b0}}};
    assign uy    = {i_pixel_y, 1'b1, {(SUBPIXEL_BITS-1){1'b0}}};
    assign n_adx = (ux >= i_center_x) ? ux - i_center_x : i_center_x - ux;
    assign n_ady = (uy >= i_center_y) ? uy - i_center_y : i_center_y - uy;
    // round(a * 65536 / 255) = a * 257 + (a >= 128)
    assign n_ca  = ONE_W'({i_dest_alpha, i_dest_alpha}) + ONE_W'(i_dest_alpha[7]);

    logic                            r_s1_valid, r_s2_valid, r_s3_valid;
    logic [CEN_W-1:0]                r_s1_adx, r_s1_ady;
    logic [bdpc_pkg::RAD_W-1:0]      r_s1_rad;
    bdpc_pkg::t_pix                  r_s1_pix, r_s2_pix, r_s3_pix;
    bdpc_pkg::t_pix                  n_s3_pix;
    logic [SQ_W-1:0]                 r_s2_sqx, r_s2_sqy;
    logic [R2W-1:0]                  r_s2_r2, r_s3_r2;
    logic [R2W-1:0]                  r_s3_d2;
    logic [D2_W-1:0]                 n_d2;

    assign n_d2 = D2_W'(r_s2_sqx) + D2_W'(r_s2_sqy);

    always_comb begin
        n_s3_pix        = r_s2_pix;
        n_s3_pix.in_dab = CMPD_W'(n_d2) < CMPD_W'(r_s2_r2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_adx        <= n_adx;
            r_s1_ady        <= n_ady;
            r_s1_rad        <= i_dab_radius;
            r_s1_pix.red    <= i_dest_red;
            r_s1_pix.green  <= i_dest_green;
            r_s1_pix.blue   <= i_dest_blue;
            r_s1_pix.alpha  <= i_dest_alpha;
            r_s1_pix.ca     <= n_ca;
            r_s1_pix.in_dab <= 1'b0;

            r_s2_sqx <= SQ_W'(r_s1_adx) * SQ_W'(r_s1_adx);
            r_s2_sqy <= SQ_W'(r_s1_ady) * SQ_W'(r_s1_ady);
            r_s2_r2  <= R2W'(r_s1_rad) * R2W'(r_s1_rad);
            r_s2_pix <= r_s1_pix;

            r_s3_d2  <= R2W'(n_d2);
            r_s3_r2  <= r_s2_r2;
            r_s3_pix <= n_s3_pix;
        end
    end

    // ---------------- normalised distance ----------------
    logic              rd_valid;
    logic [FRAC_W-1:0] rd_d;
    logic [PIX_W-1:0]  rd_sb;
    bdpc_pkg::t_pix    rd_pix;

    bdpc_rootdiv #(
        .RAD_W (bdpc_pkg::RAD_W),
        .QUO_W (FRAC_W),
        .SB_W  (PIX_W)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_valid),
        .i_d2    (r_s3_d2),
        .i_r2    (r_s3_r2),
        .i_sb    (r_s3_pix),
        .o_valid (rd_valid),
        .o_quo   (rd_d),
        .o_sb    (rd_sb)
    );

    assign rd_pix = bdpc_pkg::t_pix'(rd_sb);

    // ---------------- hardness split ----------------
    logic [TNUM_W-1:0] n_dk, n_hk;
    logic              n_tzero;
    logic              r_n_valid;
    logic [TNUM_W-1:0] r_n_num;
    logic [PCT_W-1:0]  r_n_den;
    logic [PIX_W:0]    r_n_sb;

    assign n_dk    = TNUM_W'(rd_d) * TNUM_W'(bdpc_pkg::PCT_MAX);
    assign n_hk    = TNUM_W'({hard_sat, {FRAC_W{1'b0}}});
    assign n_tzero = n_dk <= n_hk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (en) begin
            r_n_valid <= rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_num <= n_tzero ? '0 : n_dk - n_hk;
            r_n_den <= bdpc_pkg::PCT_MAX - hard_sat;
            r_n_sb  <= {n_tzero, rd_pix};
        end
    end

    logic              td_valid;
    logic [FRAC_W-1:0] td_q;
    logic [PIX_W:0]    td_sb;

    bdpc_udiv #(
        .NUM_W (TNUM_W),
        .DEN_W (PCT_W),
        .QUO_W (FRAC_W),
        .SB_W  (PIX_W + 1)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_valid),
        .i_num   (r_n_num),
        .i_den   (r_n_den),
        .i_sb    (r_n_sb),
        .o_valid (td_valid),
        .o_quo   (td_q),
        .o_sb    (td_sb)
    );

    // ---------------- smoothstep, flow, over ----------------
    logic [FRAC_W-1:0] n_t;
    logic [49:0]       n_ps;
    logic [ONE_W-1:0]  n_s;
    logic [ONE_W-1:0]  n_a;
    logic [ONE_W:0]    n_ta_raw;

    assign n_t      = td_sb[PIX_W] ? '0 : td_q;

    logic [6:1]        r_t_valid;
    bdpc_pkg::t_pix    r_t1_pix, r_t2_pix, r_t3_pix, r_t4_pix, r_t5_pix, r_t6_pix;
    logic [31:0]       r_t1_tt;
    logic [17:0]       r_t1_w;
    logic [49:0]       r_t2_p;
    logic [TNUM_W-1:0] r_t3_x;
    logic [DV_W-1:0]   r_t4_prod;
    logic [33:0]       r_t5_cp;
    logic [ONE_W-1:0]  r_t6_ta;

    assign n_ps     = r_t2_p + bdpc_pkg::ROUND32;
    assign n_s      = n_ps[48:32];
    assign n_a      = r_t4_prod[DV_SH+ONE_W-1:DV_SH];
    assign n_ta_raw = (ONE_W+1)'(r_t5_pix.ca) + (ONE_W+1)'(r_t5_cp[33:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= '0;
        end else if (en) begin
            r_t_valid <= {r_t_valid[5:1], td_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_pix  <= bdpc_pkg::t_pix'(td_sb[PIX_W-1:0]);
            r_t1_tt   <= 32'(n_t) * 32'(n_t);
            r_t1_w    <= bdpc_pkg::SMOOTH_K - {1'b0, n_t, 1'b0};

            r_t2_pix  <= r_t1_pix;
            r_t2_p    <= 50'(r_t1_tt) * 50'(r_t1_w);

            r_t3_pix  <= r_t2_pix;
            r_t3_x    <= TNUM_W'(flow_sat) * TNUM_W'(bdpc_pkg::Q16_ONE - n_s) + TNUM_W'(50);

            r_t4_pix  <= r_t3_pix;
            r_t4_prod <= DV_W'(r_t3_x) * DV_W'(bdpc_pkg::DIV100_M);

            r_t5_pix  <= r_t4_pix;
            r_t5_cp   <= 34'(n_a) * 34'(bdpc_pkg::Q16_ONE - r_t4_pix.ca);

            r_t6_pix  <= r_t5_pix;
            r_t6_ta   <= (n_ta_raw > (ONE_W+1)'(r_op)) ? r_op : n_ta_raw[ONE_W-1:0];
        end
    end

    // ---------------- mix share ----------------
    bdpc_pkg::t_blend n_bld;
    logic             r_t7_valid;
    bdpc_pkg::t_blend r_t7_bld;
    logic [MNUM_W-1:0] r_t7_num;

    always_comb begin
        n_bld.red   = r_t6_pix.red;
        n_bld.green = r_t6_pix.green;
        n_bld.blue  = r_t6_pix.blue;
        n_bld.alpha = r_t6_pix.alpha;
        n_bld.wr    = r_t6_pix.in_dab && (r_t6_ta != '0);
        n_bld.ta    = r_t6_ta;
        if (r_t6_pix.ca <= bdpc_pkg::CA_TINY) begin
            n_bld.mode = bdpc_pkg::MIX_FULL;
        end else if (r_t6_ta <= r_t6_pix.ca) begin
            n_bld.mode = bdpc_pkg::MIX_ZERO;
        end else begin
            n_bld.mode = bdpc_pkg::MIX_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t7_valid <= 1'b0;
        end else if (en) begin
            r_t7_valid <= r_t_valid[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t7_bld <= n_bld;
            r_t7_num <= {r_t6_ta - r_t6_pix.ca, {FRAC_W{1'b0}}};
        end
    end

    logic              md_valid;
    logic [FRAC_W-1:0] md_q;
    logic [BLD_W-1:0]  md_sb;

    bdpc_udiv #(
        .NUM_W (MNUM_W),
        .DEN_W (ONE_W),
        .QUO_W (FRAC_W),
        .SB_W  (BLD_W)
    ) u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_t7_valid),
        .i_num   (r_t7_num),
        .i_den   (r_t7_bld.ta),
        .i_sb    (r_t7_bld),
        .o_valid (md_valid),
        .o_quo   (md_q),
        .o_sb    (md_sb)
    );

    // ---------------- blend and output ----------------
    bdpc_pkg::t_blend md_bld;
    logic [ONE_W-1:0] n_mix;
    logic [24:0]      n_al;

    assign md_bld = bdpc_pkg::t_blend'(md_sb);
    assign n_al   = 25'(md_bld.ta) * 25'(255) + bdpc_pkg::ROUND16;

    always_comb begin
        case (md_bld.mode)
            bdpc_pkg::MIX_FULL: n_mix = bdpc_pkg::Q16_ONE;
            bdpc_pkg::MIX_ZERO: n_mix = '0;
            bdpc_pkg::MIX_DIV:  n_mix = {1'b0, md_q};
            default:            n_mix = '0;
        endcase
    end

    logic [bdpc_pkg::CH_W-1:0] r_out_red, r_out_green, r_out_blue, r_out_alpha;
    logic                      r_out_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= md_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_we <= md_bld.wr;
            if (md_bld.wr) begin
                r_out_red   <= bdpc_pkg::blend8(md_bld.red,   r_color[23:16], n_mix);
                r_out_green <= bdpc_pkg::blend8(md_bld.green, r_color[15:8],  n_mix);
                r_out_blue  <= bdpc_pkg::blend8(md_bld.blue,  r_color[7:0],   n_mix);
                r_out_alpha <= n_al[23:16];
            end else begin
                r_out_red   <= md_bld.red;
                r_out_green <= md_bld.green;
                r_out_blue  <= md_bld.blue;
                r_out_alpha <= md_bld.alpha;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_red      = r_out_red;
    assign o_out_green    = r_out_green;
    assign o_out_blue     = r_out_blue;
    assign o_out_alpha    = r_out_alpha;
    assign o_write_enable = r_out_we;

    // ---------------- assertions ----------------
    a_ta_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_valid[6] |-> r_t6_ta <= r_op)
        else $error("alpha above opacity ceiling");

    a_ta_lowered_only_by_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_valid[6] |-> (r_t6_ta >= r_t6_pix.ca) || (r_t6_ta == r_op))
        else $error("alpha dropped below existing without the cap");

    a_mix_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t7_valid && (r_t7_bld.mode == bdpc_pkg::MIX_DIV) |-> r_t7_bld.ta != '0)
        else $error("mix divide with zero alpha");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule
